FILE: hdl/v2fx_pkg.sv
// ----------------------------------------------------------------------------
// v2fx_pkg: shared codes for the 2D fixed-point vector unit
// Opcode width and opcode values used by the lanes and the top level.
// ----------------------------------------------------------------------------
package v2fx_pkg;

    localparam int OP_W = 3;

    localparam logic [OP_W-1:0] OP_ADD   = 3'd0;
    localparam logic [OP_W-1:0] OP_SUB   = 3'd1;
    localparam logic [OP_W-1:0] OP_SCALE = 3'd2;
    localparam logic [OP_W-1:0] OP_LEN   = 3'd3;
    localparam logic [OP_W-1:0] OP_DIST  = 3'd4;
    localparam logic [OP_W-1:0] OP_NORM  = 3'd5;

endpackage

FILE: hdl/v2fx_lane.sv
// ----------------------------------------------------------------------------
// v2fx_lane: one component lane
// Three stages: add/sub/multiply, then clamp and magnitude, then square of
// the magnitude that feeds the length path.
// ----------------------------------------------------------------------------
module v2fx_lane #(
    parameter int DW = 32,
    parameter int FB = 16
) (
    input  logic                         aclk,
    input  logic                         en,
    input  logic [v2fx_pkg::OP_W-1:0]    op,
    input  logic signed [DW-1:0]         a,
    input  logic signed [DW-1:0]         b,
    input  logic signed [DW-1:0]         sf,
    output logic signed [DW-1:0]         res,
    output logic                         sat,
    output logic [2*DW-1:0]              sq,
    output logic [DW-1:0]                amag,
    output logic                         aneg
);

    localparam logic signed [DW-1:0] VMAX = {1'b0, {(DW-1){1'b1}}};
    localparam logic signed [DW-1:0] VMIN = {1'b1, {(DW-1){1'b0}}};

    // stage 1
    logic [v2fx_pkg::OP_W-1:0] op1_reg;
    logic signed [DW-1:0]      a1_reg;
    logic [DW:0]               sum1_reg, sum1_next;
    logic [DW:0]               dif1_reg, dif1_next;
    logic signed [2*DW-1:0]    prod1_reg, prod1_next;

    // stage 2
    logic signed [DW-1:0]      res2_reg, res2_next;
    logic                      sat2_reg, sat2_next;
    logic [DW:0]               sqop2_reg, sqop2_next;
    logic [DW-1:0]             amag2_reg, amag2_next;
    logic                      aneg2_reg;

    // stage 3
    logic signed [DW-1:0]      res_reg;
    logic                      sat_reg;
    logic [2*DW-1:0]           sq_reg;
    logic [DW-1:0]             amag_reg;
    logic                      aneg_reg;
    logic [2*DW+1:0]           sq_full;

    logic                      sum_ovf, dif_ovf, scl_ovf;
    logic [DW-FB:0]            hi;
    logic [DW:0]               dmag;

    // exact sum, difference and product
    assign sum1_next  = {a[DW-1], a} + {b[DW-1], b};
    assign dif1_next  = {a[DW-1], a} - {b[DW-1], b};
    assign prod1_next = a * sf;

    always_ff @(posedge aclk) begin
        if (en) begin
            op1_reg   <= op;
            a1_reg    <= a;
            sum1_reg  <= sum1_next;
            dif1_reg  <= dif1_next;
            prod1_reg <= prod1_next;
        end
    end

    // clamp per opcode, pick the operand to square
    assign sum_ovf = sum1_reg[DW] ^ sum1_reg[DW-1];
    assign dif_ovf = dif1_reg[DW] ^ dif1_reg[DW-1];
    assign hi      = prod1_reg[2*DW-1:DW-1+FB];
    assign scl_ovf = !((&hi) || !(|hi));
    assign dmag    = dif1_reg[DW] ? (DW+1)'(-dif1_reg) : dif1_reg;

    always_comb begin
        res2_next = '0;
        sat2_next = 1'b0;
        unique case (op1_reg)
            v2fx_pkg::OP_ADD: begin
                sat2_next = sum_ovf;
                res2_next = sum_ovf ? (sum1_reg[DW] ? VMIN : VMAX) : sum1_reg[DW-1:0];
            end
            v2fx_pkg::OP_SUB: begin
                sat2_next = dif_ovf;
                res2_next = dif_ovf ? (dif1_reg[DW] ? VMIN : VMAX) : dif1_reg[DW-1:0];
            end
            v2fx_pkg::OP_SCALE: begin
                sat2_next = scl_ovf;
                res2_next = scl_ovf ? (prod1_reg[2*DW-1] ? VMIN : VMAX)
                                    : prod1_reg[DW-1+FB:FB];
            end
            default: begin
                res2_next = '0;
                sat2_next = 1'b0;
            end
        endcase
        amag2_next = a1_reg[DW-1] ? DW'(-a1_reg) : DW'(a1_reg);
        sqop2_next = (op1_reg == v2fx_pkg::OP_DIST) ? dmag : {1'b0, amag2_next};
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            res2_reg  <= res2_next;
            sat2_reg  <= sat2_next;
            sqop2_reg <= sqop2_next;
            amag2_reg <= amag2_next;
            aneg2_reg <= a1_reg[DW-1];
        end
    end

    // square, kept to 2*DW bits
    assign sq_full = sqop2_reg * sqop2_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            res_reg  <= res2_reg;
            sat_reg  <= sat2_reg;
            sq_reg   <= sq_full[2*DW-1:0];
            amag_reg <= amag2_reg;
            aneg_reg <= aneg2_reg;
        end
    end

    assign res  = res_reg;
    assign sat  = sat_reg;
    assign sq   = sq_reg;
    assign amag = amag_reg;
    assign aneg = aneg_reg;

endmodule

FILE: hdl/v2fx_sqrt.sv
// ----------------------------------------------------------------------------
// v2fx_sqrt: pipelined floor square root
// One root bit per stage, DW stages, restoring digit-by-digit method.
// ----------------------------------------------------------------------------
module v2fx_sqrt #(
    parameter int DW = 32
) (
    input  logic              aclk,
    input  logic              en,
    input  logic [2*DW-1:0]   rad,
    output logic [DW-1:0]     root
);

    localparam int RW = DW + 3;

    logic [RW-1:0]   rem_reg  [DW];
    logic [DW-1:0]   root_reg [DW];
    logic [2*DW-1:0] rad_reg  [DW];

    for (genvar k = 0; k < DW; k++) begin : g_stage
        logic [RW-1:0]   r_in;
        logic [DW-1:0]   q_in;
        logic [2*DW-1:0] n_in;
        logic [RW-1:0]   t;
        logic [RW-1:0]   trial;
        logic            ge;

        if (k == 0) begin : g_first
            assign r_in = '0;
            assign q_in = '0;
            assign n_in = rad;
        end else begin : g_next
            assign r_in = rem_reg[k-1];
            assign q_in = root_reg[k-1];
            assign n_in = rad_reg[k-1];
        end

        // bring down two radicand bits, try root*4+1
        assign t     = {r_in[RW-3:0], n_in[2*DW-1 -: 2]};
        assign trial = {1'b0, q_in, 2'b01};
        assign ge    = (t >= trial);

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[k]  <= ge ? (t - trial) : t;
                root_reg[k] <= {q_in[DW-2:0], ge};
            end
        end

        if (k < DW - 1) begin : g_pass
            always_ff @(posedge aclk) begin
                if (en) begin
                    rad_reg[k] <= {n_in[2*DW-3:0], 2'b00};
                end
            end
        end
    end

    assign root = root_reg[DW-1];

endmodule

FILE: hdl/v2fx_div.sv
// ----------------------------------------------------------------------------
// v2fx_div: pipelined unsigned divider for normalize
// Quotient (num << FB) / den, FB+1 quotient bits, one bit per stage.
// The quotient never exceeds 1.0 since num is at most the length.
// ----------------------------------------------------------------------------
module v2fx_div #(
    parameter int DW = 32,
    parameter int FB = 16
) (
    input  logic            aclk,
    input  logic            en,
    input  logic [DW-1:0]   num,
    input  logic [DW:0]     den,
    output logic [FB:0]     quo
);

    localparam int NW = DW + FB;
    localparam int CW = DW + FB + 1;

    logic [NW-1:0] rem_reg [FB+1];
    logic [DW:0]   den_reg [FB+1];
    logic [FB:0]   quo_reg [FB+1];

    for (genvar k = 0; k <= FB; k++) begin : g_stage
        logic [NW-1:0] r_in;
        logic [DW:0]   d_in;
        logic [FB:0]   q_in;
        logic [CW-1:0] dsh;
        logic          ge;

        if (k == 0) begin : g_first
            assign r_in = {num, {FB{1'b0}}};
            assign d_in = den;
            assign q_in = '0;
        end else begin : g_next
            assign r_in = rem_reg[k-1];
            assign d_in = den_reg[k-1];
            assign q_in = quo_reg[k-1];
        end

        // compare against the divisor aligned to this quotient bit
        assign dsh = CW'(d_in) << (FB - k);
        assign ge  = ({1'b0, r_in} >= dsh);

        always_ff @(posedge aclk) begin
            if (en) begin
                quo_reg[k] <= {q_in[FB-1:0], ge};
            end
        end

        if (k < FB) begin : g_pass
            always_ff @(posedge aclk) begin
                if (en) begin
                    rem_reg[k] <= ge ? (r_in - dsh[NW-1:0]) : r_in;
                    den_reg[k] <= d_in;
                end
            end
        end
    end

    assign quo = quo_reg[FB];

endmodule

FILE: hdl/vector2_fixed_point_unit.sv
// ----------------------------------------------------------------------------
// vector2_fixed_point_unit: 2D fixed-point vector arithmetic
// Add, subtract, scale, length, distance and normalize on signed Q-format
// components, fully pipelined.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter on the s_ stream: opcode, vector A, vector B and a scale
//   factor packed in s_tdata. Each request yields exactly one result on the
//   m_ stream: result_x, result_y, zero_length and saturated in m_tdata.
//   Throughput is one request per cycle while s_tready is high. Latency is
//   the same for every opcode: x and y lanes run three stages, then a
//   sum-of-squares stage, a DATA_WIDTH-stage square root, a length stage,
//   two FRAC_BITS+1 stage dividers and an output register. The square root
//   and divider depth set the latency.
//   The pipeline advances whenever the output register is free or about to
//   be read, or the last stage holds no request; so s_tready drops only
//   while a result waits in the output register and the stage behind it is
//   full. Results stay stable while m_tready is low.
//   Reset (aresetn low at a clock edge) empties the pipeline and the output
//   register; the unit holds no other state.
// ----------------------------------------------------------------------------
module vector2_fixed_point_unit #(
    parameter int DATA_WIDTH = 32,
    parameter int FRAC_BITS  = 16
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // opcode, a_x, a_y, b_x, b_y, scale_factor (low to high), zero padded
    input  logic [((v2fx_pkg::OP_W+5*DATA_WIDTH+7)/8)*8-1:0] s_tdata,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // result_x, result_y, zero_length, saturated (low to high), zero padded
    output logic [((2*DATA_WIDTH+2+7)/8)*8-1:0]             m_tdata
);

    localparam int DW   = DATA_WIDTH;
    localparam int FB   = FRAC_BITS;
    localparam int OPW  = v2fx_pkg::OP_W;
    localparam int M_W  = ((2*DW+2+7)/8)*8;
    localparam int N    = 6 + DW + FB;
    localparam logic signed [DW-1:0] VMAX = {1'b0, {(DW-1){1'b1}}};

    typedef struct packed {
        logic [OPW-1:0]       op;
        logic signed [DW-1:0] rx;
        logic signed [DW-1:0] ry;
        logic                 sat;
        logic                 nx;
        logic                 ny;
        logic [DW-1:0]        mx;
        logic [DW-1:0]        my;
        logic                 carry;
        logic                 zero;
    } side_t;

    logic          en, out_load;
    logic [N-1:0]  vld_reg;

    logic [OPW-1:0]       in_op;
    logic signed [DW-1:0] in_ax, in_ay, in_bx, in_by, in_sf;

    logic [OPW-1:0]       op_d_reg [3];

    logic signed [DW-1:0] rx_l, ry_l;
    logic                 satx_l, saty_l;
    logic [2*DW-1:0]      sqx_l, sqy_l;
    logic [DW-1:0]        magx_l, magy_l;
    logic                 negx_l, negy_l;

    logic [2*DW:0]        ssum;
    logic [2*DW-1:0]      rad_reg;
    side_t                sb4_reg, sb4_next;
    side_t                sq_sb_reg [DW];
    logic [DW-1:0]        root;

    side_t                sbp_reg, sbp_next;
    logic [DW:0]          den_reg, den_next;
    logic                 len_ovf;
    side_t                dv_sb_reg [FB+1];
    logic [FB:0]          qx, qy;

    side_t                fb;
    logic signed [DW-1:0] qx_e, qy_e, rx_f, ry_f;

    logic                 m_tvalid_reg;
    logic [M_W-1:0]       m_tdata_reg, m_tdata_next;

    // request fields
    assign in_op = s_tdata[OPW-1:0];
    assign in_ax = s_tdata[OPW +: DW];
    assign in_ay = s_tdata[OPW+DW +: DW];
    assign in_bx = s_tdata[OPW+2*DW +: DW];
    assign in_by = s_tdata[OPW+3*DW +: DW];
    assign in_sf = s_tdata[OPW+4*DW +: DW];

    // pipeline advance and output load
    assign out_load = !m_tvalid_reg || m_tready;
    assign en       = out_load || !vld_reg[N-1];
    assign s_tready = en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (en) begin
                vld_reg <= {vld_reg[N-2:0], s_tvalid};
            end
            if (out_load) begin
                m_tvalid_reg <= vld_reg[N-1];
            end
        end
    end

    // opcode alongside the lanes
    always_ff @(posedge aclk) begin
        if (en) begin
            op_d_reg[0] <= in_op;
            op_d_reg[1] <= op_d_reg[0];
            op_d_reg[2] <= op_d_reg[1];
        end
    end

    v2fx_lane #(.DW(DW), .FB(FB)) u_lane_x (
        .aclk (aclk), .en (en), .op (in_op),
        .a (in_ax), .b (in_bx), .sf (in_sf),
        .res (rx_l), .sat (satx_l), .sq (sqx_l), .amag (magx_l), .aneg (negx_l)
    );

    v2fx_lane #(.DW(DW), .FB(FB)) u_lane_y (
        .aclk (aclk), .en (en), .op (in_op),
        .a (in_ay), .b (in_by), .sf (in_sf),
        .res (ry_l), .sat (saty_l), .sq (sqy_l), .amag (magy_l), .aneg (negy_l)
    );

    // merge lanes: sum of squares, carry out marks overflow
    assign ssum = {1'b0, sqx_l} + {1'b0, sqy_l};

    always_comb begin
        sb4_next       = '0;
        sb4_next.op    = op_d_reg[2];
        sb4_next.rx    = rx_l;
        sb4_next.ry    = ry_l;
        sb4_next.sat   = satx_l | saty_l;
        sb4_next.nx    = negx_l;
        sb4_next.ny    = negy_l;
        sb4_next.mx    = magx_l;
        sb4_next.my    = magy_l;
        sb4_next.carry = ssum[2*DW];
        sb4_next.zero  = 1'b0;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            rad_reg <= ssum[2*DW-1:0];
            sb4_reg <= sb4_next;
        end
    end

    v2fx_sqrt #(.DW(DW)) u_sqrt (
        .aclk (aclk), .en (en), .rad (rad_reg), .root (root)
    );

    // side data follows the square root stages
    always_ff @(posedge aclk) begin
        if (en) begin
            sq_sb_reg[0] <= sb4_reg;
            for (int i = 1; i < DW; i++) begin
                sq_sb_reg[i] <= sq_sb_reg[i-1];
            end
        end
    end

    // length result, zero test and divisor
    assign len_ovf = sq_sb_reg[DW-1].carry || root[DW-1];

    always_comb begin
        sbp_next = sq_sb_reg[DW-1];
        if (sbp_next.op == v2fx_pkg::OP_LEN || sbp_next.op == v2fx_pkg::OP_DIST) begin
            sbp_next.rx  = len_ovf ? VMAX : root;
            sbp_next.sat = len_ovf;
        end
        sbp_next.zero = (sbp_next.op == v2fx_pkg::OP_NORM) && !sbp_next.carry
                        && (root == '0);
        den_next = sbp_next.carry ? {1'b1, {DW{1'b0}}} : {1'b0, root};
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            sbp_reg <= sbp_next;
            den_reg <= den_next;
        end
    end

    v2fx_div #(.DW(DW), .FB(FB)) u_div_x (
        .aclk (aclk), .en (en), .num (sbp_reg.mx), .den (den_reg), .quo (qx)
    );

    v2fx_div #(.DW(DW), .FB(FB)) u_div_y (
        .aclk (aclk), .en (en), .num (sbp_reg.my), .den (den_reg), .quo (qy)
    );

    // side data follows the divider stages
    always_ff @(posedge aclk) begin
        if (en) begin
            dv_sb_reg[0] <= sbp_reg;
            for (int i = 1; i <= FB; i++) begin
                dv_sb_reg[i] <= dv_sb_reg[i-1];
            end
        end
    end

    // final select: normalize takes signed quotients
    assign fb   = dv_sb_reg[FB];
    assign qx_e = DW'(qx);
    assign qy_e = DW'(qy);

    always_comb begin
        rx_f = fb.rx;
        ry_f = fb.ry;
        if (fb.op == v2fx_pkg::OP_NORM) begin
            if (fb.zero) begin
                rx_f = '0;
                ry_f = '0;
            end else begin
                rx_f = fb.nx ? -qx_e : qx_e;
                ry_f = fb.ny ? -qy_e : qy_e;
            end
        end
        m_tdata_next = M_W'({fb.sat, fb.zero, ry_f, rx_f});
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_tdata_reg <= m_tdata_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

`ifndef SYNTH
    a_zero_gives_null: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[2*DW]) |-> (m_tdata[2*DW-1:0] == '0))
        else $error("zero_length result carries nonzero components");

    a_flags_exclusive: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_tdata[2*DW] && m_tdata[2*DW+1]))
        else $error("zero_length and saturated both set");

    a_stall_only_on_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (m_tvalid && !m_tready))
        else $error("input stalled while output free");

    a_result_from_pipe: assert property (@(posedge aclk) disable iff (!aresetn)
        ($rose(m_tvalid)) |-> $past(vld_reg[N-1]))
        else $error("result appeared without a request in the last stage");
`endif

endmodule

FILE: bench/vector2_fixed_point_unit_tb.sv
// ----------------------------------------------------------------------------
// vector2_fixed_point_unit_tb: self-checking bench for the 2D vector unit
// Drives requests on the s_ stream from a directed table and then at random,
// predicts each result in a local model and compares it in order with the
// results taken from the m_ stream. Both sides idle and stall at random.
// ----------------------------------------------------------------------------
module vector2_fixed_point_unit_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int OP_W    = v2fx_pkg::OP_W;
    localparam int DW      = 32;
    localparam int FB      = 16;
    localparam int S_W     = ((OP_W + 5*DW + 7)/8)*8;
    localparam int M_W     = ((2*DW + 2 + 7)/8)*8;
    localparam int LAT     = DW + FB + 7;
    localparam int N_RAND  = 1780;
    localparam int HOLD_CY = 150;

    localparam logic signed [DW-1:0] VMAX = {1'b0, {(DW-1){1'b1}}};
    localparam logic signed [DW-1:0] VMIN = {1'b1, {(DW-1){1'b0}}};
    localparam logic signed [DW-1:0] ONE  = 32'sh0001_0000;

    typedef struct packed {
        logic signed [DW-1:0] sf;
        logic signed [DW-1:0] by;
        logic signed [DW-1:0] bx;
        logic signed [DW-1:0] ay;
        logic signed [DW-1:0] ax;
        logic [OP_W-1:0]      op;
    } vec_req_t;

    typedef struct packed {
        logic                 sat;
        logic                 zero;
        logic signed [DW-1:0] ry;
        logic signed [DW-1:0] rx;
    } vec_res_t;

    typedef struct {
        vec_req_t req;
        logic     has_res;
        vec_res_t res;
    } table_row_t;

    logic           aclk = 1'b0;
    logic           aresetn = 1'b0;
    logic           s_tvalid = 1'b0;
    logic           s_tready;
    logic [S_W-1:0] s_tdata = '0;
    logic           m_tvalid;
    logic           m_tready = 1'b0;
    logic [M_W-1:0] m_tdata;

    vec_res_t   expected_results[$];
    int         error_count = 0;
    logic       sink_hold = 1'b0;
    logic       calm_phase = 1'b0;
    table_row_t directed[$];

    vector2_fixed_point_unit #(.DATA_WIDTH(DW), .FRAC_BITS(FB)) uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    always #6 aclk = ~aclk;

    // run limit
    initial begin
        #(12ns * 400000);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // floor square root of an unsigned 128-bit value
    function automatic logic [63:0] floor_sqrt(input logic [127:0] n);
        logic [127:0] r;
        logic [127:0] b;
        r = '0;
        b = 128'd1 << 126;
        while (b > n) b = b >> 2;
        while (b != 0) begin
            if (n >= r + b) begin
                n = n - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r[63:0];
    endfunction

    function automatic logic signed [DW-1:0] clip(input logic signed [127:0] v,
                                                  inout logic sat);
        if (v > VMAX) begin
            sat = 1'b1;
            return VMAX;
        end
        if (v < VMIN) begin
            sat = 1'b1;
            return VMIN;
        end
        return v[DW-1:0];
    endfunction

    // length of (x,y): the sum of squares beyond 64 bits saturates
    function automatic logic signed [DW-1:0] vec_length(input logic signed [DW:0] x,
                                                        input logic signed [DW:0] y,
                                                        inout logic sat);
        logic signed [127:0] xs, ys;
        logic [127:0]        ss;
        logic [63:0]         r;
        xs = x;
        ys = y;
        ss = xs*xs + ys*ys;
        if (ss[127:64] != 0) begin
            sat = 1'b1;
            return VMAX;
        end
        r = floor_sqrt(ss);
        if (r > 64'(VMAX)) begin
            sat = 1'b1;
            return VMAX;
        end
        return r[DW-1:0];
    endfunction

    function automatic logic signed [DW-1:0] unit_part(input logic signed [DW-1:0] c,
                                                       input logic [127:0] len);
        logic signed [127:0] cw;
        logic [127:0]        m, q;
        cw = c;
        m = (cw < 0) ? -cw : cw;
        q = (m << FB) / len;
        return (cw < 0) ? -q[DW-1:0] : q[DW-1:0];
    endfunction

    function automatic vec_res_t vector_op(input vec_req_t q);
        vec_res_t            r;
        logic                sat;
        logic signed [127:0] ax, ay, bx, by, sf, p;
        logic [127:0]        ss;
        r = '0;
        sat = 1'b0;
        ax = q.ax; ay = q.ay; bx = q.bx; by = q.by; sf = q.sf;
        case (q.op)
            v2fx_pkg::OP_ADD: begin
                r.rx = clip(ax + bx, sat);
                r.ry = clip(ay + by, sat);
            end
            v2fx_pkg::OP_SUB: begin
                r.rx = clip(ax - bx, sat);
                r.ry = clip(ay - by, sat);
            end
            v2fx_pkg::OP_SCALE: begin
                p = ax * sf;
                r.rx = clip(p >>> FB, sat);
                p = ay * sf;
                r.ry = clip(p >>> FB, sat);
            end
            v2fx_pkg::OP_LEN: r.rx = vec_length(33'(q.ax), 33'(q.ay), sat);
            v2fx_pkg::OP_DIST: r.rx = vec_length(33'(ax - bx), 33'(ay - by), sat);
            v2fx_pkg::OP_NORM: begin
                ss = ax*ax + ay*ay;
                if (ss == 0) begin
                    r.zero = 1'b1;
                end else begin
                    ss = (ss[127:64] != 0) ? (128'd1 << 32) : 128'(floor_sqrt(ss));
                    r.rx = unit_part(q.ax, ss);
                    r.ry = unit_part(q.ay, ss);
                end
            end
            default: ;
        endcase
        r.sat = sat;
        return r;
    endfunction

    function automatic logic signed [DW-1:0] rand_comp();
        case ($urandom_range(0, 5))
            0: return VMAX - $urandom_range(0, 3);
            1: return VMIN + $urandom_range(0, 3);
            2: return $signed($urandom_range(0, 8*65536)) - 4*65536;
            3: return $signed($urandom_range(0, 64)) - 32;
            default: return $urandom;
        endcase
    endfunction

    function automatic vec_req_t random_req();
        vec_req_t q;
        q.op = ($urandom_range(0, 19) == 0) ? OP_W'($urandom_range(6, 7))
                                           : OP_W'($urandom_range(0, 5));
        q.ax = rand_comp();
        q.ay = rand_comp();
        q.bx = rand_comp();
        q.by = rand_comp();
        q.sf = rand_comp();
        return q;
    endfunction

    // drive one request and wait until it is accepted; valid stays high
    // so the next request can follow in the very next cycle
    task automatic send_request(input vec_req_t q, input logic gaps);
        while (gaps && !calm_phase && $urandom_range(0, 99) < 12) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= S_W'(q);
        expected_results.push_back(vector_op(q));
        do @(posedge aclk); while (!s_tready);
    endtask

    // result sink: random stalls, long hold-off when requested
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            m_tready <= !sink_hold && (calm_phase || $urandom_range(0, 99) >= 12);
        end
    end

    // result checker
    always @(posedge aclk) begin
        vec_res_t got, want;
        if (aresetn && m_tvalid && m_tready) begin
            got = m_tdata[2*DW+1:0];
            if (expected_results.size() == 0) begin
                $error("result with no request pending: %h", got);
                error_count++;
            end else begin
                want = expected_results.pop_front();
                if (got.rx !== want.rx) begin
                    $error("result_x expected %h actual %h", want.rx, got.rx);
                    error_count++;
                end
                if (got.ry !== want.ry) begin
                    $error("result_y expected %h actual %h", want.ry, got.ry);
                    error_count++;
                end
                if (got.zero !== want.zero) begin
                    $error("zero_length expected %b actual %b", want.zero, got.zero);
                    error_count++;
                end
                if (got.sat !== want.sat) begin
                    $error("saturated expected %b actual %b", want.sat, got.sat);
                    error_count++;
                end
            end
        end
    end

    task automatic add_row(input logic [OP_W-1:0] op, input logic signed [DW-1:0] ax,
                           input logic signed [DW-1:0] ay, input logic signed [DW-1:0] bx,
                           input logic signed [DW-1:0] by, input logic signed [DW-1:0] sf,
                           input logic has, input logic signed [DW-1:0] rx,
                           input logic signed [DW-1:0] ry, input logic z, input logic s);
        table_row_t t;
        t.req = '{sf: sf, by: by, bx: bx, ay: ay, ax: ax, op: op};
        t.has_res = has;
        t.res = '{sat: s, zero: z, ry: ry, rx: rx};
        directed.push_back(t);
    endtask

    // stimulus
    initial begin
        vec_res_t model;
        int       wait_cy;
        // directed table: typed results where obvious
        add_row(v2fx_pkg::OP_ADD, VMAX, VMIN, ONE, -ONE, 0, 1, VMAX, VMIN, 0, 1);
        add_row(v2fx_pkg::OP_ADD, VMIN, VMAX, VMIN, VMAX, 0, 1, VMIN, VMAX, 0, 1);
        add_row(v2fx_pkg::OP_ADD, ONE, -ONE, ONE, ONE, 0, 1, 2*ONE, 0, 0, 0);
        add_row(v2fx_pkg::OP_SUB, VMIN, VMAX, ONE, -ONE, 0, 1, VMIN, VMAX, 0, 1);
        add_row(v2fx_pkg::OP_SUB, 0, 0, VMIN, VMAX, 0, 1, VMAX, -VMAX, 0, 1);
        add_row(v2fx_pkg::OP_SCALE, ONE, -ONE, 0, 0, 2*ONE, 1, 2*ONE, -2*ONE, 0, 0);
        add_row(v2fx_pkg::OP_SCALE, VMAX, VMIN, 0, 0, VMAX, 1, VMAX, VMIN, 0, 1);
        add_row(v2fx_pkg::OP_SCALE, VMIN, VMIN, 0, 0, VMIN, 0, 0, 0, 0, 0);
        add_row(v2fx_pkg::OP_SCALE, -1, 1, 0, 0, 1, 1, -1, 0, 0, 0);
        add_row(v2fx_pkg::OP_LEN, 3*ONE, 4*ONE, 0, 0, 0, 1, 5*ONE, 0, 0, 0);
        add_row(v2fx_pkg::OP_LEN, VMIN, VMIN, 0, 0, 0, 0, 0, 0, 0, 0);
        add_row(v2fx_pkg::OP_LEN, 0, 0, 0, 0, 0, 1, 0, 0, 0, 0);
        add_row(v2fx_pkg::OP_DIST, VMAX, VMAX, VMIN, VMIN, 0, 1, VMAX, 0, 0, 1);
        add_row(v2fx_pkg::OP_DIST, ONE, ONE, ONE, ONE, 0, 1, 0, 0, 0, 0);
        add_row(v2fx_pkg::OP_DIST, VMIN, 0, VMAX, 0, 0, 0, 0, 0, 0, 0);
        add_row(v2fx_pkg::OP_NORM, 0, 0, 0, 0, 0, 1, 0, 0, 1, 0);
        add_row(v2fx_pkg::OP_NORM, 2*ONE, 0, 0, 0, 0, 1, ONE, 0, 0, 0);
        add_row(v2fx_pkg::OP_NORM, VMIN, VMIN, 0, 0, 0, 0, 0, 0, 0, 0);
        add_row(v2fx_pkg::OP_NORM, VMAX, -1, 0, 0, 0, 0, 0, 0, 0, 0);
        add_row(v2fx_pkg::OP_NORM, 1, -1, 0, 0, 0, 0, 0, 0, 0, 0);
        add_row(3'd6, VMAX, VMIN, -1, 1, VMIN, 1, 0, 0, 0, 0);
        add_row(3'd7, -1, -1, -1, -1, -1, 1, 0, 0, 0, 0);

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (directed[i]) begin
            if (directed[i].has_res) begin
                model = vector_op(directed[i].req);
                if (model !== directed[i].res) begin
                    $error("table row %0d disagrees with predictor", i);
                    error_count++;
                end
            end
            send_request(directed[i].req, 1'b1);
        end
        s_tvalid <= 1'b0;

        // sender pause until every result is in
        wait_cy = 0;
        while (expected_results.size() != 0 && wait_cy < 100000) begin
            @(posedge aclk);
            wait_cy++;
        end

        // receiver hold-off while the sender keeps the pipe full
        fork
            begin
                sink_hold = 1'b1;
                repeat (HOLD_CY) @(posedge aclk);
                sink_hold = 1'b0;
            end
            begin
                for (int i = 0; i < 100; i++) send_request(random_req(), 1'b0);
                s_tvalid <= 1'b0;
            end
        join
        @(posedge aclk);

        for (int i = 0; i < N_RAND; i++) begin
            calm_phase = (i >= 600 && i < 900);
            send_request(random_req(), 1'b1);
        end
        s_tvalid <= 1'b0;
        calm_phase = 1'b0;

        wait_cy = 0;
        while (expected_results.size() != 0 && wait_cy < 100000) begin
            @(posedge aclk);
            wait_cy++;
        end
        repeat (LAT + 10) @(posedge aclk);

        if (error_count == 0 && expected_results.size() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end
endmodule
